FILE: rtl/core/gss_pkg.sv
package gss_pkg;

  localparam int POINT_WIDTH = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int ACC_WIDTH = 31;
  localparam int ITER_WIDTH = 16;
  localparam int PROBES_WIDTH = ITER_WIDTH + 1;
  localparam int KIND_WIDTH = 2;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH = 32;

  // psi = 0.6180339887 as an unsigned fraction with PSI_FRAC bits.
  localparam int PSI_FRAC = 16;
  localparam logic [PSI_FRAC-1:0] PSI = PSI_FRAC'(40503);

  localparam logic OP_START = 1'b0;
  localparam logic OP_VALUE = 1'b1;

  localparam logic [KIND_WIDTH-1:0] KIND_PROBE = 2'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_DONE = 2'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_REJECT = 2'd2;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ACCURACY = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_ITER = 1'b1;

  typedef struct packed {
    logic                          op;
    logic signed [POINT_WIDTH-1:0] left_bound;
    logic signed [POINT_WIDTH-1:0] right_bound;
    logic signed [VALUE_WIDTH-1:0] probe_value;
  } in_item_t;

  typedef struct packed {
    logic [KIND_WIDTH-1:0]         kind;
    logic signed [POINT_WIDTH-1:0] point;
    logic [POINT_WIDTH-1:0]        final_width;
    logic [ITER_WIDTH-1:0]         iterations_done;
    logic [PROBES_WIDTH-1:0]       probes_done;
  } out_item_t;

endpackage

FILE: rtl/core/golden_section_min_search_unit.sv
// Golden-section minimum search controller. A start item (op 0) loads two
// bounds, swapped if out of order, and answers with a request for the function
// value at the left golden point; the value item (op 1) that follows asks for
// the right golden point, and every later value narrows the interval and asks
// for one new probe, until the iteration limit is reached or the width is no
// more than twice the accuracy, when a finished item carries the midpoint,
// width, iteration and probe counts. A value item while no search runs is
// answered with a rejection, and a start item during a search restarts it.
// Every item gets exactly one result. Each item is handled combinationally:
// the state update, one 32x16 offset multiply and the compares sit between
// the input handshake and the result register, so an item can be accepted on
// every clock, including the clock at which the previous result is taken. The
// input stalls only while a result waits in the result register under a
// stall. The rate is set by the outside evaluator, which must return each
// value before the next probe is known. Configuration is always ready and
// takes effect at once.
module golden_section_min_search_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  gss_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output gss_pkg::out_item_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gss_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [gss_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
  import gss_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_FIRST_LEFT = 2'd1;
  localparam logic [1:0] PH_RIGHT = 2'd2;
  localparam logic [1:0] PH_NEW_LEFT = 2'd3;

  localparam int PROD_WIDTH = POINT_WIDTH + PSI_FRAC;

  logic [ACC_WIDTH-1:0]   accuracy_r;
  logic [ITER_WIDTH-1:0]  max_iter_r;

  logic [1:0]             phase_r, phase_nxt;
  logic [POINT_WIDTH-1:0] low_r, low_nxt;
  logic [POINT_WIDTH-1:0] high_r, high_nxt;
  logic [POINT_WIDTH-1:0] pleft_r, pleft_nxt;
  logic [POINT_WIDTH-1:0] pright_r, pright_nxt;
  logic [VALUE_WIDTH-1:0] vleft_r, vleft_nxt;
  logic [VALUE_WIDTH-1:0] vright_r, vright_nxt;
  logic [ITER_WIDTH-1:0]  iter_r, iter_nxt;

  logic                   out_valid_r;
  out_item_t              out_data_r, out_data_nxt;

  logic                   accept;
  logic [POINT_WIDTH-1:0] start_lo, start_hi;
  logic [POINT_WIDTH-1:0] cur_width;
  logic                   keep_going;
  logic [VALUE_WIDTH-1:0] cmp_left, cmp_right;
  logic                   go_right;
  logic [POINT_WIDTH-1:0] mul_width;
  logic [PROD_WIDTH-1:0]  product;
  logic [POINT_WIDTH-1:0] offset;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    if ($signed(in_data.left_bound) > $signed(in_data.right_bound)) begin
      start_lo = in_data.right_bound;
      start_hi = in_data.left_bound;
    end else begin
      start_lo = in_data.left_bound;
      start_hi = in_data.right_bound;
    end
  end

  assign cur_width  = high_r - low_r;
  assign keep_going = (iter_r < max_iter_r) && (cur_width > {accuracy_r, 1'b0});

  // The fresh value takes the slot of the probe that was just evaluated.
  assign cmp_left  = (phase_r == PH_RIGHT) ? vleft_r : in_data.probe_value;
  assign cmp_right = (phase_r == PH_RIGHT) ? in_data.probe_value : vright_r;
  assign go_right  = $signed(cmp_left) > $signed(cmp_right);

  // One shared offset multiplier: the start width, or the width after narrowing.
  always_comb begin
    if (in_data.op == OP_START) begin
      mul_width = start_hi - start_lo;
    end else if (go_right) begin
      mul_width = high_r - pleft_r;
    end else begin
      mul_width = pright_r - low_r;
    end
  end

  assign product = PROD_WIDTH'(mul_width) * PROD_WIDTH'(PSI);
  assign offset  = product[PSI_FRAC +: POINT_WIDTH];

  always_comb begin
    phase_nxt    = phase_r;
    low_nxt      = low_r;
    high_nxt     = high_r;
    pleft_nxt    = pleft_r;
    pright_nxt   = pright_r;
    vleft_nxt    = vleft_r;
    vright_nxt   = vright_r;
    iter_nxt     = iter_r;
    out_data_nxt = '0;

    if (in_data.op == OP_START) begin
      low_nxt            = start_lo;
      high_nxt           = start_hi;
      pleft_nxt          = start_hi - offset;
      pright_nxt         = start_lo + offset;
      vleft_nxt          = '0;
      vright_nxt         = '0;
      iter_nxt           = '0;
      phase_nxt          = PH_FIRST_LEFT;
      out_data_nxt.kind  = KIND_PROBE;
      out_data_nxt.point = start_hi - offset;
    end else begin
      case (phase_r)
        PH_FIRST_LEFT: begin
          vleft_nxt          = in_data.probe_value;
          phase_nxt          = PH_RIGHT;
          out_data_nxt.kind  = KIND_PROBE;
          out_data_nxt.point = pright_r;
        end
        PH_RIGHT, PH_NEW_LEFT: begin
          if (phase_r == PH_RIGHT) begin
            vright_nxt = in_data.probe_value;
          end else begin
            vleft_nxt = in_data.probe_value;
          end
          if (keep_going) begin
            iter_nxt          = iter_r + ITER_WIDTH'(1);
            out_data_nxt.kind = KIND_PROBE;
            if (go_right) begin
              low_nxt            = pleft_r;
              pleft_nxt          = pright_r;
              vleft_nxt          = cmp_right;
              pright_nxt         = pleft_r + offset;
              phase_nxt          = PH_RIGHT;
              out_data_nxt.point = pleft_r + offset;
            end else begin
              // Equal values land here and pull the high bound in.
              high_nxt           = pright_r;
              pright_nxt         = pleft_r;
              vright_nxt         = cmp_left;
              pleft_nxt          = pright_r - offset;
              phase_nxt          = PH_NEW_LEFT;
              out_data_nxt.point = pright_r - offset;
            end
          end else begin
            phase_nxt                    = PH_IDLE;
            out_data_nxt.kind            = KIND_DONE;
            out_data_nxt.point           = low_r + (cur_width >> 1);
            out_data_nxt.final_width     = cur_width;
            out_data_nxt.iterations_done = iter_r;
            out_data_nxt.probes_done     = PROBES_WIDTH'(iter_r) + PROBES_WIDTH'(2);
          end
        end
        default: begin
          out_data_nxt.kind = KIND_REJECT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accuracy_r <= ACC_WIDTH'(66);
      max_iter_r <= ITER_WIDTH'(100);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACCURACY: accuracy_r <= cfg_data[ACC_WIDTH-1:0];
        CFG_MAX_ITER: max_iter_r <= cfg_data[ITER_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      low_r      <= low_nxt;
      high_r     <= high_nxt;
      pleft_r    <= pleft_nxt;
      pright_r   <= pright_nxt;
      vleft_r    <= vleft_nxt;
      vright_r   <= vright_nxt;
      iter_r     <= iter_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  a_value_idle_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.op == OP_VALUE && phase_r == PH_IDLE
    |=> out_valid_r && out_data_r.kind == KIND_REJECT)
    else $error("value item while idle was not rejected");

  a_start_first_left: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.op == OP_START
    |=> phase_r == PH_FIRST_LEFT && out_data_r.kind == KIND_PROBE)
    else $error("start item did not begin a search");

  a_done_probe_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.kind == KIND_DONE
    |-> out_data_r.probes_done
        == PROBES_WIDTH'(out_data_r.iterations_done) + PROBES_WIDTH'(2))
    else $error("probe count does not match iterations");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_data_r.kind == KIND_DONE || out_data_r.kind == KIND_REJECT)
               == (phase_r == PH_IDLE))
    else $error("phase disagrees with the last result kind");

endmodule
